/* hdl/phu_pkg.sv */
// Shared types, field layouts and codes of the pipeline hazard unit.
package phu_pkg;

   // Fixed geometry of the snapshot
   localparam int MAX_SOURCES    = 2;
   localparam int SOURCE_FIELDS  = 2;
   localparam int REG_INDEX_BITS = 5;
   localparam int DATA_BITS      = 32;
   localparam int COUNT_BITS     = 32;

   // Action codes, ordered by priority
   localparam logic [2:0] ACT_NONE    = 3'd0;
   localparam logic [2:0] ACT_FWD_MEM = 3'd1;
   localparam logic [2:0] ACT_FWD_EX  = 3'd2;
   localparam logic [2:0] ACT_STALL   = 3'd3;
   localparam logic [2:0] ACT_FLUSH   = 3'd4;

   localparam logic [1:0] FLUSH_STAGES = 2'd2;

   // Configuration register indexes
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ALU_COUNT      = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FP_COUNT       = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SEPARATE_PORTS = 2'd2;

   // Decode flag bits
   localparam int ID_VALID = 0;
   localparam int ID_ALU   = 1;
   localparam int ID_FP    = 2;

   // Execute flag bits
   localparam int EX_VALID     = 0;
   localparam int EX_HAS_DEST  = 1;
   localparam int EX_LOAD      = 2;
   localparam int EX_HAS_VALUE = 3;
   localparam int EX_BRANCH    = 4;
   localparam int EX_PRED      = 5;
   localparam int EX_TAKEN     = 6;
   localparam int EX_ALU       = 7;
   localparam int EX_FP        = 8;

   // Memory flag bits
   localparam int MEM_VALID     = 0;
   localparam int MEM_HAS_DEST  = 1;
   localparam int MEM_HAS_VALUE = 2;
   localparam int MEM_LOAD      = 3;
   localparam int MEM_STORE     = 4;

   // Request payload, first field in the lowest bits
   typedef struct packed {
      logic [DATA_BITS-1:0]      mem_value;
      logic [REG_INDEX_BITS-1:0] mem_reg;
      logic [4:0]                mem_flags;
      logic [DATA_BITS-1:0]      ex_value;
      logic [REG_INDEX_BITS-1:0] ex_reg;
      logic [8:0]                ex_flags;
      logic [REG_INDEX_BITS-1:0] src_b;
      logic [REG_INDEX_BITS-1:0] src_a;
      logic [1:0]                src_count;
      logic [2:0]                decode_flags;
      logic                      fetch_valid;
   } request_type;

   // Response payload, first field in the lowest bits, padded to whole bytes
   typedef struct packed {
      logic                  pad;
      logic [COUNT_BITS-1:0] total_forwards;
      logic [COUNT_BITS-1:0] total_flushes;
      logic [COUNT_BITS-1:0] total_stalls;
      logic [1:0]            flushed_stages;
      logic                  stall_flag;
      logic [DATA_BITS-1:0]  forward_value;
      logic                  forward_value_valid;
      logic [2:0]            action;
   } response_type;

   localparam int REQ_BITS = $bits(request_type);
   localparam int RSP_BITS = $bits(response_type);

   // Decision for one snapshot
   typedef struct packed {
      logic [2:0]           act;
      logic                 fvalid;
      logic [DATA_BITS-1:0] fval;
      logic                 stall;
      logic [1:0]           flush;
   } verdict_type;

   // Configuration seen by the checks
   typedef struct packed {
      logic [3:0] alu_count;
      logic [3:0] fp_unit_count;
      logic       separate_ports;
   } config_type;

endpackage

/* hdl/phu_detect.sv */
// Hazard checks (control, data, structural) and priority selection.
module phu_detect import phu_pkg::*; (
   input  request_type snap,
   input  config_type  cfg,
   output verdict_type verdict
);

   logic [2:0]           act_a, act_b, dat_act;
   logic                 fv_a, fv_b, dat_fv;
   logic [DATA_BITS-1:0] val_a, val_b, dat_val;
   logic                 use_a, use_b;
   logic                 ctl_flush, st_stall;
   logic [2:0]           best_act;
   logic                 id_valid, ex_valid;

   assign id_valid = snap.decode_flags[ID_VALID];
   assign ex_valid = snap.ex_flags[EX_VALID];

   // Per-source check: EX match wins over MEM, a load in EX stalls
   function automatic void check_source(input request_type s,
                                        input logic [REG_INDEX_BITS-1:0] src,
                                        output logic [2:0] act,
                                        output logic fv,
                                        output logic [DATA_BITS-1:0] val);
      act = ACT_NONE;
      fv  = 1'b0;
      val = '0;
      if (s.ex_flags[EX_VALID] && s.ex_flags[EX_HAS_DEST] && (s.ex_reg == src)) begin
         if (s.ex_flags[EX_LOAD]) begin
            act = ACT_STALL;
         end else begin
            act = ACT_FWD_EX;
            fv  = s.ex_flags[EX_HAS_VALUE];
            val = s.ex_value;
         end
      end else if (s.mem_flags[MEM_VALID] && s.mem_flags[MEM_HAS_DEST] &&
                   (s.mem_reg == src)) begin
         act = ACT_FWD_MEM;
         fv  = s.mem_flags[MEM_HAS_VALUE];
         val = s.mem_value;
      end
   endfunction

   // Source count clamped to the fields present
   assign use_a = id_valid && (snap.src_count >= 2'd1);
   assign use_b = id_valid && (snap.src_count >= 2'd2) &&
                  (MAX_SOURCES >= 2) && (SOURCE_FIELDS >= 2);

   // Data check: source a wins ties
   always_comb begin
      check_source(snap, snap.src_a, act_a, fv_a, val_a);
      check_source(snap, snap.src_b, act_b, fv_b, val_b);
      dat_act = ACT_NONE;
      dat_fv  = 1'b0;
      dat_val = '0;
      if (use_a) begin
         dat_act = act_a;
         dat_fv  = fv_a;
         dat_val = val_a;
      end
      if (use_b && (act_b > dat_act)) begin
         dat_act = act_b;
         dat_fv  = fv_b;
         dat_val = val_b;
      end
   end

   // Control check: mispredicted branch in EX
   assign ctl_flush = ex_valid && snap.ex_flags[EX_BRANCH] &&
                      (snap.ex_flags[EX_PRED] != snap.ex_flags[EX_TAKEN]);

   // Structural check: unit contention or shared memory port
   assign st_stall = (id_valid && ex_valid &&
                      ((snap.decode_flags[ID_ALU] && snap.ex_flags[EX_ALU] &&
                        (cfg.alu_count < 4'd2)) ||
                       (snap.decode_flags[ID_FP] && snap.ex_flags[EX_FP] &&
                        (cfg.fp_unit_count < 4'd2)))) ||
                     (!cfg.separate_ports && snap.fetch_valid &&
                      snap.mem_flags[MEM_VALID] &&
                      (snap.mem_flags[MEM_LOAD] || snap.mem_flags[MEM_STORE]));

   // Priority: flush, stall, then the data result
   always_comb begin
      if (ctl_flush) begin
         best_act = ACT_FLUSH;
      end else if (st_stall && (dat_act < ACT_STALL)) begin
         best_act = ACT_STALL;
      end else begin
         best_act = dat_act;
      end
   end

   // Only forwards carry a value
   always_comb begin
      verdict.act    = best_act;
      verdict.fvalid = 1'b0;
      verdict.fval   = '0;
      if ((best_act == ACT_FWD_EX) || (best_act == ACT_FWD_MEM)) begin
         verdict.fvalid = dat_fv;
         verdict.fval   = dat_val;
      end
      verdict.stall = (best_act == ACT_STALL);
      verdict.flush = (best_act == ACT_FLUSH) ? FLUSH_STAGES : 2'd0;
   end

endmodule

/* hdl/phu_result.sv */
// Result register and saturating statistics counters.
module phu_result import phu_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  verdict_type         verdict,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RSP_BITS-1:0] rsp_tdata
);

   logic                  valid_ff, valid_in;
   verdict_type           verdict_ff;
   logic [COUNT_BITS-1:0] stall_total_ff, stall_total_in;
   logic [COUNT_BITS-1:0] flush_total_ff, flush_total_in;
   logic [COUNT_BITS-1:0] forward_total_ff, forward_total_in;
   logic                  load;
   response_type          rsp;

   assign in_ready = !valid_ff || rsp_tready;
   assign load     = in_valid && in_ready;
   assign valid_in = load || (valid_ff && !rsp_tready);

   // Counters step when a verdict enters the result register
   always_comb begin
      stall_total_in   = stall_total_ff;
      flush_total_in   = flush_total_ff;
      forward_total_in = forward_total_ff;
      if (load) begin
         if (verdict.stall && (stall_total_ff != '1)) begin
            stall_total_in = stall_total_ff + 1'b1;
         end
         if ((verdict.act == ACT_FLUSH) && (flush_total_ff != '1)) begin
            flush_total_in = flush_total_ff + 1'b1;
         end
         if (((verdict.act == ACT_FWD_EX) || (verdict.act == ACT_FWD_MEM)) &&
             (forward_total_ff != '1)) begin
            forward_total_in = forward_total_ff + 1'b1;
         end
      end
   end

   // Control and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff         <= 1'b0;
         stall_total_ff   <= '0;
         flush_total_ff   <= '0;
         forward_total_ff <= '0;
      end else begin
         valid_ff         <= valid_in;
         stall_total_ff   <= stall_total_in;
         flush_total_ff   <= flush_total_in;
         forward_total_ff <= forward_total_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (load) begin
         verdict_ff <= verdict;
      end
   end

   always_comb begin
      rsp.pad                 = 1'b0;
      rsp.total_forwards      = forward_total_ff;
      rsp.total_flushes       = flush_total_ff;
      rsp.total_stalls        = stall_total_ff;
      rsp.flushed_stages      = verdict_ff.flush;
      rsp.stall_flag          = verdict_ff.stall;
      rsp.forward_value       = verdict_ff.fval;
      rsp.forward_value_valid = verdict_ff.fvalid;
      rsp.action              = verdict_ff.act;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = rsp;

endmodule

/* hdl/pipeline_hazard_unit.sv */
// Top level of the pipeline hazard unit: input register, CSRs, checks, result.
//
// One pipeline snapshot per clock is accepted and judged while the output is
// not stalled; each produces one result. A snapshot is captured in the input
// register, passes through the hazard checks and priority logic, and lands in
// the result register, which drives rsp_tvalid; the sustained rate is one
// transaction per cycle as long as rsp_tready is high. Backpressure on the
// result side holds the result register and then the input register. The
// statistics counters saturate at all ones and report the totals including
// the result they travel with. CSRs (alu_count, fp_unit_count, separate_ports)
// must be written only while the unit is idle; the unit does not enforce this.
module pipeline_hazard_unit import phu_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // fetch_valid, decode_flags, decode_source_count, decode_source_a,
   // decode_source_b, execute_flags, execute_dest_reg, execute_dest_value,
   // memory_flags, memory_dest_reg, memory_dest_value
   input  logic [REQ_BITS-1:0]       req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // action, forward_value_valid, forward_value, stall_flag,
   // flushed_stages, total_stalls, total_flushes, total_forwards, zero pad
   output logic [RSP_BITS-1:0]       rsp_tdata,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   logic         snap_valid_ff, snap_valid_in;
   request_type  snap_ff;
   config_type   cfg_ff, cfg_in;
   verdict_type  verdict;
   logic         result_ready;
   logic         req_take;
   response_type rsp_view;

   // Input register
   assign req_tready    = !snap_valid_ff || result_ready;
   assign req_take      = req_tvalid && req_tready;
   assign snap_valid_in = req_take || (snap_valid_ff && !result_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         snap_valid_ff <= 1'b0;
      end else begin
         snap_valid_ff <= snap_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         snap_ff <= request_type'(req_tdata);
      end
   end

   // CSR write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ALU_COUNT:      cfg_in.alu_count      = csr_wdata;
            CSR_FP_COUNT:       cfg_in.fp_unit_count  = csr_wdata;
            CSR_SEPARATE_PORTS: cfg_in.separate_ports = csr_wdata[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alu_count      <= 4'd1;
         cfg_ff.fp_unit_count  <= 4'd1;
         cfg_ff.separate_ports <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   phu_detect u_detect (
      .snap    (snap_ff),
      .cfg     (cfg_ff),
      .verdict (verdict)
   );

   phu_result u_result (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (snap_valid_ff),
      .in_ready   (result_ready),
      .verdict    (verdict),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   assign rsp_view = response_type'(rsp_tdata);

`ifndef SYNTH
   // A refused request means both registers are full and the output is stalled
   a_ready_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (snap_valid_ff && rsp_tvalid && !rsp_tready))
      else $error("request refused without full pipeline");

   // Stall totals never move backward between consecutive results
   a_stall_monotonic: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready) |=>
         (!rsp_tvalid || (rsp_view.total_stalls >= $past(rsp_view.total_stalls))))
      else $error("stall total decreased");

   // A forwarded value is flagged only on a forward action
   a_fvalid_forward: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_view.forward_value_valid) |->
         ((rsp_view.action == ACT_FWD_EX) || (rsp_view.action == ACT_FWD_MEM)))
      else $error("forward value valid without forward action");

   // Counters are cleared by reset
   a_reset_counters: assert property (@(posedge clock)
      $past(reset) |-> ((rsp_view.total_stalls == '0) &&
                        (rsp_view.total_flushes == '0) &&
                        (rsp_view.total_forwards == '0) && !rsp_tvalid))
      else $error("counters not cleared by reset");
`endif

endmodule

/* tb/pipeline_hazard_unit_tb.sv */
// Testbench for pipeline_hazard_unit: directed and random snapshots against a local predictor.
module pipeline_hazard_unit_tb;
   import phu_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   // fetch_valid, decode_flags, decode_source_count, decode_source_a,
   // decode_source_b, execute_flags, execute_dest_reg, execute_dest_value,
   // memory_flags, memory_dest_reg, memory_dest_value
   logic [REQ_BITS-1:0]       req_tdata  = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   // action, forward_value_valid, forward_value, stall_flag,
   // flushed_stages, total_stalls, total_flushes, total_forwards, zero pad
   logic [RSP_BITS-1:0]       rsp_tdata;
   logic                      csr_we     = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index  = CSR_ALU_COUNT;
   logic [CSR_DATA_BITS-1:0]  csr_wdata  = '0;

   // Shadow configuration and statistics
   logic [3:0]            cfg_alu_count  = 4'd1;
   logic [3:0]            cfg_fp_count   = 4'd1;
   logic                  cfg_split      = 1'b0;
   logic [COUNT_BITS-1:0] stall_sum      = '0;
   logic [COUNT_BITS-1:0] flush_sum      = '0;
   logic [COUNT_BITS-1:0] forward_sum    = '0;

   response_type expected_verdicts[$];
   int           mismatch_count = 0;
   int           result_count   = 0;
   int           idle_cycles    = 0;
   bit           gaps_enable    = 1'b0;
   bit           stalls_enable  = 1'b0;
   int           hold_request   = 0;

   pipeline_hazard_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic verdict_type make_verdict(logic [2:0] act);
      verdict_type v;
      v       = '0;
      v.act   = act;
      v.stall = (act == ACT_STALL);
      v.flush = (act == ACT_FLUSH) ? FLUSH_STAGES : 2'd0;
      return v;
   endfunction

   // Higher action wins; on equal action the first one is kept
   function automatic verdict_type stronger(verdict_type a, verdict_type b);
      return (b.act > a.act) ? b : a;
   endfunction

   // Data hazard of one source register against the EX and MEM destinations
   function automatic verdict_type source_hazard(logic [REG_INDEX_BITS-1:0] src,
                                                 request_type snap);
      verdict_type v;
      if (snap.ex_flags[EX_VALID] && snap.ex_flags[EX_HAS_DEST] && snap.ex_reg == src) begin
         if (snap.ex_flags[EX_LOAD]) begin
            return make_verdict(ACT_STALL);
         end
         v        = make_verdict(ACT_FWD_EX);
         v.fvalid = snap.ex_flags[EX_HAS_VALUE];
         v.fval   = snap.ex_value;
         return v;
      end
      if (snap.mem_flags[MEM_VALID] && snap.mem_flags[MEM_HAS_DEST] &&
          snap.mem_reg == src) begin
         v        = make_verdict(ACT_FWD_MEM);
         v.fvalid = snap.mem_flags[MEM_HAS_VALUE];
         v.fval   = snap.mem_value;
         return v;
      end
      return make_verdict(ACT_NONE);
   endfunction

   // Judges one snapshot and advances the saturating statistics
   function automatic response_type judge_snapshot(request_type snap);
      verdict_type  ctl, dat, st, best;
      int           n;
      response_type rsp;
      ctl = make_verdict(ACT_NONE);
      dat = make_verdict(ACT_NONE);
      st  = make_verdict(ACT_NONE);

      // mispredicted branch in EX
      if (snap.ex_flags[EX_VALID] && snap.ex_flags[EX_BRANCH] &&
          snap.ex_flags[EX_PRED] != snap.ex_flags[EX_TAKEN])
         ctl = make_verdict(ACT_FLUSH);

      // source count clamps to what the snapshot carries
      n = snap.src_count;
      if (n > MAX_SOURCES) n = MAX_SOURCES;
      if (n > SOURCE_FIELDS) n = SOURCE_FIELDS;
      if (snap.decode_flags[ID_VALID]) begin
         if (n >= 1) dat = stronger(dat, source_hazard(snap.src_a, snap));
         if (n >= 2) dat = stronger(dat, source_hazard(snap.src_b, snap));
      end

      // execution unit contention, then shared memory port
      if (snap.decode_flags[ID_VALID] && snap.ex_flags[EX_VALID] &&
          ((snap.decode_flags[ID_ALU] && snap.ex_flags[EX_ALU] && cfg_alu_count < 2) ||
           (snap.decode_flags[ID_FP] && snap.ex_flags[EX_FP] && cfg_fp_count < 2)))
         st = make_verdict(ACT_STALL);
      else if (!cfg_split && snap.fetch_valid && snap.mem_flags[MEM_VALID] &&
               (snap.mem_flags[MEM_LOAD] || snap.mem_flags[MEM_STORE]))
         st = make_verdict(ACT_STALL);

      best = stronger(stronger(ctl, dat), st);

      if (best.stall && stall_sum != '1) stall_sum++;
      if (best.act == ACT_FLUSH && flush_sum != '1) flush_sum++;
      if ((best.act == ACT_FWD_EX || best.act == ACT_FWD_MEM) && forward_sum != '1)
         forward_sum++;

      rsp                     = '0;
      rsp.action              = best.act;
      rsp.forward_value_valid = best.fvalid;
      rsp.forward_value       = best.fval;
      rsp.stall_flag          = best.stall;
      rsp.flushed_stages      = best.flush;
      rsp.total_stalls        = stall_sum;
      rsp.total_flushes       = flush_sum;
      rsp.total_forwards      = forward_sum;
      return rsp;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(string what);
      mismatch_count++;
      $display("result %0d: %s", result_count, what);
   endtask

   task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s is %h, predicted %h", name, got, want));
   endtask

   always @(posedge clock) begin
      response_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = response_type'(rsp_tdata);
         if (expected_verdicts.size() == 0) begin
            report_mismatch("result arrived with none predicted");
         end else begin
            want = expected_verdicts.pop_front();
            compare_field("action", 32'(got.action), 32'(want.action));
            compare_field("forward_value_valid", 32'(got.forward_value_valid),
                          32'(want.forward_value_valid));
            compare_field("forward_value", got.forward_value, want.forward_value);
            compare_field("stall_flag", 32'(got.stall_flag), 32'(want.stall_flag));
            compare_field("flushed_stages", 32'(got.flushed_stages),
                          32'(want.flushed_stages));
            compare_field("total_stalls", got.total_stalls, want.total_stalls);
            compare_field("total_flushes", got.total_flushes, want.total_flushes);
            compare_field("total_forwards", got.total_forwards, want.total_forwards);
         end
         result_count++;
      end
   end

   // Watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Result-side ready: long hold-offs on request, else short random stalls
   initial begin
      int hold_left;
      int stall_left;
      hold_left  = 0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (stalls_enable && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            stall_left = $urandom_range(0, 2);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- driving

   task automatic send_snapshot(request_type snap);
      int gap;
      if (gaps_enable && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         gap = $urandom_range(1, 3);
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= snap;
      do @(posedge clock); while (!req_tready);
      expected_verdicts.push_back(judge_snapshot(snap));
   endtask

   // Stop offering and wait until every predicted result has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic apply_config(logic [3:0] alus, logic [3:0] fps, logic split);
      drain_results();
      csr_we    <= 1'b1;
      csr_index <= CSR_ALU_COUNT;
      csr_wdata <= alus;
      @(posedge clock);
      csr_index <= CSR_FP_COUNT;
      csr_wdata <= fps;
      @(posedge clock);
      csr_index <= CSR_SEPARATE_PORTS;
      csr_wdata <= {{(CSR_DATA_BITS-1){1'b0}}, split};
      @(posedge clock);
      csr_we        <= 1'b0;
      cfg_alu_count = alus;
      cfg_fp_count  = fps;
      cfg_split     = split;
   endtask

   function automatic logic [31:0] random_value();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // Random snapshot; register indices mostly from a small pool so they collide
   function automatic request_type random_snapshot();
      request_type snap;
      bit          crowded;
      crowded           = ($urandom_range(0, 3) != 0);
      snap.fetch_valid  = 1'($urandom_range(0, 1));
      snap.decode_flags = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 4) != 0) snap.decode_flags[ID_VALID] = 1'b1;
      snap.src_count    = 2'($urandom_range(0, 3));
      snap.src_a        = REG_INDEX_BITS'(crowded ? $urandom_range(0, 3) :
                                                    $urandom_range(0, 31));
      snap.src_b        = REG_INDEX_BITS'(crowded ? $urandom_range(0, 3) :
                                                    $urandom_range(0, 31));
      snap.ex_flags     = 9'($urandom_range(0, 511));
      if ($urandom_range(0, 3) != 0) snap.ex_flags[EX_VALID] = 1'b1;
      if ($urandom_range(0, 2) != 0) snap.ex_flags[EX_HAS_DEST] = 1'b1;
      snap.ex_reg       = REG_INDEX_BITS'(crowded ? $urandom_range(0, 3) :
                                                    $urandom_range(0, 31));
      snap.ex_value     = random_value();
      snap.mem_flags    = 5'($urandom_range(0, 31));
      if ($urandom_range(0, 3) != 0) snap.mem_flags[MEM_VALID] = 1'b1;
      snap.mem_reg      = REG_INDEX_BITS'(crowded ? $urandom_range(0, 3) :
                                                    $urandom_range(0, 31));
      snap.mem_value    = random_value();
      return snap;
   endfunction

   task automatic send_random(int count);
      repeat (count) send_snapshot(random_snapshot());
   endtask

   // ---------------------------------------------------------------- tests

   // Runs at the reset configuration: one ALU, one FP unit, shared memory port
   task automatic test_directed();
      request_type base, snap;
      base = '0;

      // empty pipeline
      send_snapshot(base);

      // bubble in ID: matching EX destination and shared ALU are ignored
      snap              = base;
      snap.decode_flags = 3'((1 << ID_ALU) | (1 << ID_FP));
      snap.src_count    = 2'd2;
      snap.src_a        = 5'd5;
      snap.ex_flags     = 9'((1 << EX_VALID) | (1 << EX_HAS_DEST) | (1 << EX_ALU) |
                             (1 << EX_FP));
      snap.ex_reg       = 5'd5;
      send_snapshot(snap);

      // load-use stall
      snap              = base;
      snap.decode_flags = 3'(1 << ID_VALID);
      snap.src_count    = 2'd1;
      snap.src_a        = 5'd7;
      snap.ex_flags     = 9'((1 << EX_VALID) | (1 << EX_HAS_DEST) | (1 << EX_LOAD));
      snap.ex_reg       = 5'd7;
      send_snapshot(snap);

      // forward from EX, highest register and value
      snap.src_a    = 5'd31;
      snap.ex_reg   = 5'd31;
      snap.ex_flags = 9'((1 << EX_VALID) | (1 << EX_HAS_DEST) | (1 << EX_HAS_VALUE));
      snap.ex_value = '1;
      send_snapshot(snap);

      // forward from EX without a value still carries the destination value
      snap.ex_flags = 9'((1 << EX_VALID) | (1 << EX_HAS_DEST));
      snap.ex_value = 32'h0000_1234;
      send_snapshot(snap);

      // forward from MEM through source b, register zero, value zero
      snap              = base;
      snap.decode_flags = 3'(1 << ID_VALID);
      snap.src_count    = 2'd2;
      snap.src_a        = 5'd9;
      snap.src_b        = 5'd0;
      snap.mem_flags    = 5'((1 << MEM_VALID) | (1 << MEM_HAS_DEST) | (1 << MEM_HAS_VALUE));
      snap.mem_reg      = 5'd0;
      snap.mem_value    = '0;
      send_snapshot(snap);

      // forward from MEM without a value
      snap.mem_flags = 5'((1 << MEM_VALID) | (1 << MEM_HAS_DEST));
      snap.mem_value = 32'hdead_beef;
      send_snapshot(snap);

      // EX and MEM both write the source: EX is the younger producer
      snap.src_b    = 5'd12;
      snap.mem_reg  = 5'd12;
      snap.ex_reg   = 5'd12;
      snap.ex_flags = 9'((1 << EX_VALID) | (1 << EX_HAS_DEST) | (1 << EX_HAS_VALUE));
      snap.ex_value = 32'h5555_aaaa;
      send_snapshot(snap);

      // source a forwards from MEM, source b from EX: EX wins
      snap.src_a   = 5'd3;
      snap.mem_reg = 5'd3;
      snap.src_b   = 5'd4;
      snap.ex_reg  = 5'd4;
      send_snapshot(snap);

      // source count above two is clamped, so source b still counts
      snap.src_count = 2'd3;
      snap.src_a     = 5'd20;
      snap.mem_reg   = 5'd21;
      send_snapshot(snap);

      // no sources read: matches are ignored
      snap.src_count = 2'd0;
      snap.src_a     = 5'd4;
      send_snapshot(snap);

      // one source read: a match on source b is ignored
      snap.src_count = 2'd1;
      snap.src_a     = 5'd30;
      send_snapshot(snap);

      // branch predicted taken, not taken
      snap          = base;
      snap.ex_flags = 9'((1 << EX_VALID) | (1 << EX_BRANCH) | (1 << EX_PRED));
      send_snapshot(snap);

      // branch predicted not taken, taken, together with a load-use: flush wins
      snap.decode_flags = 3'(1 << ID_VALID);
      snap.src_count    = 2'd1;
      snap.src_a        = 5'd8;
      snap.ex_reg       = 5'd8;
      snap.ex_flags     = 9'((1 << EX_VALID) | (1 << EX_BRANCH) | (1 << EX_TAKEN) |
                             (1 << EX_HAS_DEST) | (1 << EX_LOAD));
      send_snapshot(snap);

      // branch predicted correctly
      snap          = base;
      snap.ex_flags = 9'((1 << EX_VALID) | (1 << EX_BRANCH) | (1 << EX_PRED) |
                         (1 << EX_TAKEN));
      send_snapshot(snap);

      // mispredicted branch in an invalid EX slot
      snap.ex_flags = 9'((1 << EX_BRANCH) | (1 << EX_PRED));
      send_snapshot(snap);

      // ALU contention
      snap              = base;
      snap.decode_flags = 3'((1 << ID_VALID) | (1 << ID_ALU));
      snap.ex_flags     = 9'((1 << EX_VALID) | (1 << EX_ALU));
      send_snapshot(snap);

      // FP contention
      snap.decode_flags = 3'((1 << ID_VALID) | (1 << ID_FP));
      snap.ex_flags     = 9'((1 << EX_VALID) | (1 << EX_FP));
      send_snapshot(snap);

      // fetch against a load in MEM on the shared port
      snap             = base;
      snap.fetch_valid = 1'b1;
      snap.mem_flags   = 5'((1 << MEM_VALID) | (1 << MEM_LOAD));
      send_snapshot(snap);

      // fetch against a store in MEM, while a MEM forward is also possible: stall wins
      snap.decode_flags = 3'(1 << ID_VALID);
      snap.src_count    = 2'd1;
      snap.src_a        = 5'd17;
      snap.mem_reg      = 5'd17;
      snap.mem_flags    = 5'((1 << MEM_VALID) | (1 << MEM_STORE) | (1 << MEM_HAS_DEST) |
                             (1 << MEM_HAS_VALUE));
      snap.mem_value    = 32'h8000_0001;
      send_snapshot(snap);

      // every field at its maximum
      send_snapshot('1);
   endtask

   // Several resource settings, the extremes among them
   task automatic test_config_sweep();
      gaps_enable   = 1'b1;
      stalls_enable = 1'b1;
      apply_config(4'd0, 4'd0, 1'b0);
      send_random(40);
      apply_config(4'd1, 4'd15, 1'b1);
      send_random(40);
      apply_config(4'd2, 4'd1, 1'b0);
      send_random(40);
      apply_config(4'd15, 4'd2, 1'b1);
      send_random(40);
      apply_config(4'd0, 4'd15, 1'b0);
      send_random(40);
      apply_config(4'd15, 4'd0, 1'b1);
      send_random(40);
      apply_config(4'd2, 4'd2, 1'b0);
      send_random(40);
   endtask

   // Receiver holds off long enough for the unit to fill and stall its input
   task automatic test_backpressure();
      gaps_enable   = 1'b0;
      stalls_enable = 1'b0;
      apply_config(4'd1, 4'd1, 1'b0);
      hold_request = 60;
      send_random(40);
   endtask

   // Random snapshots under random configurations; the tail runs without idling
   task automatic test_random();
      gaps_enable   = 1'b1;
      stalls_enable = 1'b1;
      repeat (4) begin
         apply_config(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                      1'($urandom_range(0, 1)));
         send_random(100);
      end
      apply_config(4'($urandom_range(0, 3)), 4'($urandom_range(0, 3)),
                   1'($urandom_range(0, 1)));
      gaps_enable   = 1'b0;
      stalls_enable = 1'b0;
      send_random(60);
   endtask

   // Counter saturation at all ones is out of reach in a run of this length.
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_config_sweep();
      test_backpressure();
      test_random();
      drain_results();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
